FILE: sv/ppxc_pkg.sv
// ----------------------------------------------------------------------------
// Packet payload XOR cipher package
// Widths, register indexes and fixed constants shared by the cipher block
// and its channel interfaces.
// ----------------------------------------------------------------------------
package ppxc_pkg;

   localparam int BYTE_W   = 8;
   localparam int POS_W    = 16;
   localparam int SLOT_W   = 4;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 64;

   typedef logic [BYTE_W-1:0]     byte_type;
   typedef logic [POS_W-1:0]      pos_type;
   typedef logic [SLOT_W-1:0]     slot_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   // Configuration register indexes.
   localparam csr_idx_type CSR_KEY_LOW  = csr_idx_type'(0);
   localparam csr_idx_type CSR_KEY_LAST = csr_idx_type'(1);

   // Header positions within a packet.
   localparam pos_type POS_FIRST   = pos_type'(0);
   localparam pos_type POS_LEN_HI  = pos_type'(1);
   localparam pos_type POS_LEN_LO  = pos_type'(2);
   localparam pos_type POS_ROUND   = pos_type'(4);
   localparam pos_type HEADER_LEN  = pos_type'(5);
   localparam pos_type LEN_LIMIT   = pos_type'(16'h8000);
   localparam pos_type POS_MAX     = pos_type'(16'hFFFF);

   // Number of key bytes and the index of the last one.
   localparam slot_type KEY_LEN      = slot_type'(9);
   localparam slot_type KEY_SLOT_TOP = slot_type'(8);

endpackage

FILE: sv/ppxc_if.sv
// ----------------------------------------------------------------------------
// Cipher channel interfaces
// Valid/ready channels for the input bytes, the result bytes and the
// configuration writes.
// ----------------------------------------------------------------------------
interface ppxc_req_if;
   logic               valid;
   logic               ready;
   ppxc_pkg::byte_type byte_in;
   logic               packet_start;

   modport source (output valid, output byte_in, output packet_start, input ready);
   modport sink   (input valid, input byte_in, input packet_start, output ready);
endinterface

interface ppxc_rsp_if;
   logic               valid;
   logic               ready;
   ppxc_pkg::byte_type byte_out;
   logic               was_ciphered;

   modport source (output valid, output byte_out, output was_ciphered, input ready);
   modport sink   (input valid, input byte_out, input was_ciphered, output ready);
endinterface

interface ppxc_csr_if;
   logic                   valid;
   logic                   ready;
   ppxc_pkg::csr_idx_type  index;
   ppxc_pkg::csr_data_type data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/packet_payload_xor_cipher.sv
// ----------------------------------------------------------------------------
// Packet payload XOR cipher
// A result appears on the response channel in the cycle after its input
// transfer. One byte per cycle while the receiver is ready; the single result
// register is the only stage and reloads in the same cycle its byte is taken.
// Reset (synchronous, active high) clears the key registers, the packet
// position, length, round byte, key slot, group number and length flag.
// ----------------------------------------------------------------------------
module packet_payload_xor_cipher (
   input  logic            clock,
   input  logic            reset,
   ppxc_req_if.sink        req_if,
   ppxc_rsp_if.source      rsp_if,
   ppxc_csr_if.sink        csr_if
);

   // Key storage. Key bytes 0 to 7 live in the low word, byte k in bits
   // 8k+7 down to 8k; the ninth key byte has a register of its own.
   logic [63:0]        key_low_ff;
   ppxc_pkg::byte_type key_last_ff;

   // Per-packet tracking state.
   ppxc_pkg::pos_type  pos_ff,    pos_in;
   ppxc_pkg::pos_type  len_ff,    len_in;
   ppxc_pkg::byte_type round_ff,  round_in;
   ppxc_pkg::slot_type slot_ff,   slot_in;
   ppxc_pkg::byte_type group_ff,  group_in;
   logic               len_ok_ff, len_ok_in;

   // Result register.
   logic               rsp_valid_ff;
   ppxc_pkg::byte_type rsp_byte_ff, rsp_byte_in;
   logic               rsp_ciph_ff, rsp_ciph_in;

   logic               req_fire;
   ppxc_pkg::pos_type  pos_cur;
   ppxc_pkg::slot_type slot_eff;
   ppxc_pkg::slot_type slot_nxt;
   ppxc_pkg::byte_type key_sel;
   ppxc_pkg::pos_type  len_full;
   logic               in_payload;

   // The configuration port never stalls.
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_last_ff <= '0;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            ppxc_pkg::CSR_KEY_LOW:  key_low_ff  <= csr_if.data;
            ppxc_pkg::CSR_KEY_LAST: key_last_ff <= csr_if.data[7:0];
            default: ;
         endcase
      end
   end

   // A new byte is taken whenever the result register is empty or its
   // current content leaves in this same cycle.
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_fire     = req_if.valid && req_if.ready;

   // A start flag forces position zero; otherwise the tracked position holds.
   assign pos_cur = req_if.packet_start ? ppxc_pkg::POS_FIRST : pos_ff;

   // The slot stays within 0 to 8 by construction; anything else folds to 0.
   assign slot_eff = (slot_ff < ppxc_pkg::KEY_LEN) ? slot_ff : '0;

   always_comb begin
      if (slot_eff == ppxc_pkg::KEY_SLOT_TOP) begin
         key_sel = key_last_ff;
      end else begin
         key_sel = key_low_ff[{slot_eff[2:0], 3'b000} +: 8];
      end
   end

   assign in_payload = (pos_cur >= ppxc_pkg::HEADER_LEN) && len_ok_ff && (pos_cur < len_ff);
   assign slot_nxt   = slot_eff + ppxc_pkg::slot_type'(1);
   assign len_full   = {len_ff[15:8], req_if.byte_in};

   always_comb begin
      pos_in      = pos_ff;
      len_in      = len_ff;
      round_in    = round_ff;
      slot_in     = slot_ff;
      group_in    = group_ff;
      len_ok_in   = len_ok_ff;
      rsp_byte_in = req_if.byte_in;
      rsp_ciph_in = 1'b0;

      if (pos_cur == ppxc_pkg::POS_FIRST) begin
         slot_in   = '0;
         group_in  = '0;
         len_ok_in = 1'b0;
      end else if (pos_cur == ppxc_pkg::POS_LEN_HI) begin
         len_in = {req_if.byte_in, 8'h00};
      end else if (pos_cur == ppxc_pkg::POS_LEN_LO) begin
         len_in    = len_full;
         len_ok_in = (len_full >= ppxc_pkg::HEADER_LEN) && (len_full < ppxc_pkg::LEN_LIMIT);
      end else if (pos_cur == ppxc_pkg::POS_ROUND) begin
         round_in = req_if.byte_in;
      end else if (in_payload) begin
         // Key byte first, then the group number unless it equals the
         // round byte, then the round byte itself.
         rsp_byte_in = req_if.byte_in ^ key_sel ^ round_ff ^
                       ((group_ff != round_ff) ? group_ff : 8'h00);
         rsp_ciph_in = 1'b1;
         if (slot_nxt >= ppxc_pkg::KEY_LEN) begin
            slot_in  = '0;
            group_in = group_ff + 8'd1;
         end else begin
            slot_in = slot_nxt;
         end
      end

      // The position saturates so a very long stream never wraps back into
      // the header region.
      pos_in = (pos_cur < ppxc_pkg::POS_MAX) ? pos_cur + ppxc_pkg::pos_type'(1) : pos_cur;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         len_ff    <= '0;
         round_ff  <= '0;
         slot_ff   <= '0;
         group_ff  <= '0;
         len_ok_ff <= 1'b0;
      end else if (req_fire) begin
         pos_ff    <= pos_in;
         len_ff    <= len_in;
         round_ff  <= round_in;
         slot_ff   <= slot_in;
         group_ff  <= group_in;
         len_ok_ff <= len_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_byte_ff <= rsp_byte_in;
         rsp_ciph_ff <= rsp_ciph_in;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.byte_out     = rsp_byte_ff;
   assign rsp_if.was_ciphered = rsp_ciph_ff;

   // The key slot never leaves the range of the nine key bytes.
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff < ppxc_pkg::KEY_LEN)
      else $error("key slot out of range");

   // Every accepted byte yields a result in the following cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted byte produced no result");

   // Header bytes are never ciphered.
   a_header_clear: assert property (@(posedge clock) disable iff (reset)
      (req_fire && pos_cur < ppxc_pkg::HEADER_LEN) |=> !rsp_ciph_ff)
      else $error("header byte marked as ciphered");

   // Ciphering requires an accepted length.
   a_len_needed: assert property (@(posedge clock) disable iff (reset)
      (req_fire && rsp_ciph_in) |-> len_ok_ff)
      else $error("byte ciphered without a valid length");

endmodule

FILE: tb/ppxc_result_checker.sv
// ----------------------------------------------------------------------------
// Cipher result checker
// Watches the byte, result and register channels of the payload cipher,
// keeps its own copy of the packet state and key, predicts every result
// byte and compares it with what the block returns.
// ----------------------------------------------------------------------------
module ppxc_result_checker (
   input  logic clock,
   input  logic reset,
   ppxc_req_if  req_mon,
   ppxc_rsp_if  rsp_mon,
   ppxc_csr_if  csr_mon,
   output int   mismatch_count,
   output int   pending_count
);

   typedef struct packed {
      ppxc_pkg::byte_type data;
      logic               ciph;
   } cipher_out_type;

   // Key copy, updated on every register write transfer to a key index.
   ppxc_pkg::csr_data_type key_low;
   ppxc_pkg::byte_type     key_last;

   // Packet tracking state.
   ppxc_pkg::pos_type  next_pos;
   ppxc_pkg::pos_type  pkt_len;
   ppxc_pkg::byte_type round_b;
   ppxc_pkg::byte_type group_n;
   ppxc_pkg::slot_type slot_n;
   logic               len_ok;

   cipher_out_type expected_bytes[$];
   int             fail_total = 0;

   task automatic note_failure(input string msg);
      fail_total++;
      if (fail_total <= 10) $display("%s", msg);
   endtask

   // Works out the result for one input byte and advances the packet state.
   function automatic cipher_out_type predict_cipher(input ppxc_pkg::byte_type din,
                                                     input logic first);
      ppxc_pkg::pos_type  at;
      ppxc_pkg::slot_type s;
      ppxc_pkg::byte_type key_val;
      cipher_out_type     r;
      at     = first ? ppxc_pkg::POS_FIRST : next_pos;
      r.data = din;
      r.ciph = 1'b0;
      if (at == ppxc_pkg::POS_FIRST) begin
         slot_n = '0;
         group_n = '0;
         len_ok = 1'b0;
      end else if (at == ppxc_pkg::POS_LEN_HI) begin
         pkt_len = {din, 8'h00};
      end else if (at == ppxc_pkg::POS_LEN_LO) begin
         pkt_len = pkt_len | ppxc_pkg::pos_type'(din);
         len_ok  = (pkt_len >= ppxc_pkg::HEADER_LEN) && (pkt_len < ppxc_pkg::LEN_LIMIT);
      end else if (at == ppxc_pkg::POS_ROUND) begin
         round_b = din;
      end else if (at >= ppxc_pkg::HEADER_LEN && len_ok && at < pkt_len) begin
         s       = (slot_n < ppxc_pkg::KEY_LEN) ? slot_n : '0;
         key_val = (s < ppxc_pkg::KEY_SLOT_TOP) ? key_low[s*8 +: 8] : key_last;
         r.data  = r.data ^ key_val;
         if (group_n != round_b) r.data = r.data ^ group_n;
         r.data  = r.data ^ round_b;
         r.ciph  = 1'b1;
         s       = s + 1'b1;
         if (s >= ppxc_pkg::KEY_LEN) begin
            s = '0;
            group_n = group_n + 1'b1;
         end
         slot_n = s;
      end
      next_pos = (at < ppxc_pkg::POS_MAX) ? at + 1'b1 : ppxc_pkg::POS_MAX;
      return r;
   endfunction

   always @(posedge clock) begin
      cipher_out_type exp_r;
      if (reset) begin
         key_low  <= '0;
         key_last <= '0;
         next_pos <= '0;
         pkt_len  <= '0;
         round_b  <= '0;
         group_n  <= '0;
         slot_n   <= '0;
         len_ok   <= 1'b0;
         expected_bytes.delete();
      end else begin
         // A result leaves no earlier than the cycle after its byte, so the
         // comparison is made before this edge's input is predicted.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_bytes.size() == 0) begin
               note_failure($sformatf("unexpected result: byte %h ciphered %b",
                                      rsp_mon.byte_out, rsp_mon.was_ciphered));
            end else begin
               exp_r = expected_bytes.pop_front();
               if (rsp_mon.byte_out !== exp_r.data || rsp_mon.was_ciphered !== exp_r.ciph)
                  note_failure($sformatf(
                     "result mismatch: expected byte %h ciphered %b, got byte %h ciphered %b",
                     exp_r.data, exp_r.ciph, rsp_mon.byte_out, rsp_mon.was_ciphered));
            end
         end
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               ppxc_pkg::CSR_KEY_LOW:  key_low = csr_mon.data;
               ppxc_pkg::CSR_KEY_LAST: key_last = csr_mon.data[7:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            expected_bytes.push_back(predict_cipher(req_mon.byte_in, req_mon.packet_start));
      end
      pending_count  <= reset ? 0 : expected_bytes.size();
      mismatch_count <= fail_total;
   end

endmodule

FILE: tb/tb_packet_payload_xor_cipher.sv
// ----------------------------------------------------------------------------
// Payload cipher testbench
// Streams directed and random packets through the payload XOR cipher under
// several key settings and flow-control patterns, while a separate checker
// predicts every result byte and counts mismatches.
// ----------------------------------------------------------------------------
module tb_packet_payload_xor_cipher;

   // An index that maps to no register; writes to it must change nothing.
   localparam ppxc_pkg::csr_idx_type CSR_IDX_SPARE = ppxc_pkg::csr_idx_type'(8'hFF);

   // Directed bytes: bit 8 is the start flag, bits 7:0 the byte value.
   localparam logic [8:0] DIRECTED_BYTES [26] = '{
      // First packet after reset with no start flag: length 7, round byte
      // zero, so the group number matches the round byte and is skipped.
      // Two payload bytes at the extremes and one trailer byte.
      9'h0FF, 9'h000, 9'h007, 9'h0FF, 9'h000, 9'h0FF, 9'h000, 9'h0AA,
      // Length of five: empty payload, round byte all ones, then a trailer.
      9'h180, 9'h000, 9'h005, 9'h033, 9'h0FF, 9'h0C3,
      // Length at the upper limit is invalid, so nothing is ciphered.
      9'h100, 9'h080, 9'h000, 9'h001, 9'h002, 9'h0FF,
      // Length below five is invalid as well.
      9'h1FF, 9'h000, 9'h004, 9'h0FF, 9'h001, 9'h055
   };

   logic clock;
   logic reset;

   int sender_idle_pct = 0;
   int sink_stall_pct  = 0;
   int phase_items     = 0;
   int errors;
   int pending;

   ppxc_req_if req_bus ();
   ppxc_rsp_if rsp_bus ();
   ppxc_csr_if csr_bus ();

   packet_payload_xor_cipher uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   // The checker only watches the channels; it drives nothing on them.
   ppxc_result_checker result_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_mon        (csr_bus),
      .mismatch_count (errors),
      .pending_count  (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // The receiver decides each cycle whether it takes a result. With a stall
   // rate of zero it is always ready.
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
   end

   // Offers one byte and holds it until the block takes it. Idle cycles are
   // inserted in front of the byte at the sender's idle rate. Valid stays
   // high afterwards, so back-to-back bytes follow each other without a gap.
   task automatic push_byte(input ppxc_pkg::byte_type value, input logic first);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.byte_in      <= value;
      req_bus.packet_start <= first;
      do @(posedge clock); while (!req_bus.ready);
      phase_items++;
   endtask

   // Stops offering bytes and waits until every predicted result has
   // arrived, then lets the single output stage settle.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (2) @(posedge clock);
   endtask

   // One register write transfer. Valid is left high so that writes can
   // follow each other; the caller lowers it after the last one.
   task automatic write_reg(input ppxc_pkg::csr_idx_type idx,
                            input ppxc_pkg::csr_data_type value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
   endtask

   // Sends one random packet. Most packets carry a valid header with a short
   // payload, some a longer one so that the group number passes the round
   // byte; others have an invalid length, are cut short by the next packet,
   // carry extra trailer bytes, or are plain noise.
   task automatic send_packet();
      int                 kind;
      int                 count;
      int                 k;
      ppxc_pkg::pos_type  plen;
      ppxc_pkg::byte_type rnd;
      kind = $urandom_range(99);
      if (kind >= 85) begin
         count = $urandom_range(1, 8);
         for (k = 0; k < count; k++)
            push_byte(ppxc_pkg::byte_type'($urandom), ($urandom_range(3) == 0));
         return;
      end
      if (kind < 70)
         plen = ($urandom_range(9) == 0) ? ppxc_pkg::pos_type'($urandom_range(41, 300))
                                         : ppxc_pkg::pos_type'($urandom_range(5, 40));
      else
         plen = $urandom_range(1) ? ppxc_pkg::pos_type'($urandom_range(0, 4))
                                  : ppxc_pkg::pos_type'($urandom_range(16'h8000, 16'hFFFF));
      if (plen >= ppxc_pkg::HEADER_LEN && plen < ppxc_pkg::LEN_LIMIT)
         count = int'(plen);
      else
         count = $urandom_range(5, 24);
      case ($urandom_range(9))
         0, 1: count = $urandom_range(1, count - 1);
         2, 3: count = count + $urandom_range(1, 6);
         default: ;
      endcase
      // Small round bytes make the group number meet the round byte often.
      rnd = $urandom_range(1) ? ppxc_pkg::byte_type'($urandom_range(0, 4))
                              : ppxc_pkg::byte_type'($urandom);
      for (k = 0; k < count; k++) begin
         case (k)
            0: push_byte(ppxc_pkg::byte_type'($urandom), ($urandom_range(15) != 0));
            1: push_byte(plen[15:8], 1'b0);
            2: push_byte(plen[7:0], 1'b0);
            4: push_byte(rnd, 1'b0);
            default: push_byte(ppxc_pkg::byte_type'($urandom), 1'b0);
         endcase
      end
   endtask

   initial begin
      int                     phase;
      logic                   pressure_done;
      ppxc_pkg::csr_data_type key_word;
      ppxc_pkg::csr_data_type last_word;

      pressure_done        = 1'b0;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.byte_in      = '0;
      req_bus.packet_start = 1'b0;
      rsp_bus.ready        = 1'b0;
      csr_bus.valid        = 1'b0;
      csr_bus.index        = '0;
      csr_bus.data         = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // A fixed key for the directed bytes, written while the block is idle
      // right after reset. The upper bits of the last-byte write are junk
      // that the block must drop.
      write_reg(ppxc_pkg::CSR_KEY_LOW, 64'hFEDC_BA98_7654_3210);
      write_reg(ppxc_pkg::CSR_KEY_LAST, {$urandom, 24'h000000, 8'h5A});
      csr_bus.valid <= 1'b0;

      foreach (DIRECTED_BYTES[k])
         push_byte(DIRECTED_BYTES[k][7:0], DIRECTED_BYTES[k][8]);
      drain_results();

      // Four phases, each with its own key and flow-control pattern:
      // no idling, a mostly idle sender, a mostly stalling receiver, and
      // both idling at a moderate rate.
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               key_word        = {$urandom, $urandom};
               last_word       = {$urandom, $urandom};
               sender_idle_pct = 0;
               sink_stall_pct  = 0;
            end
            1: begin
               key_word        = '1;
               last_word       = {$urandom, 24'h000000, 8'hFF};
               sender_idle_pct = 76;
               sink_stall_pct  = 0;
            end
            2: begin
               key_word        = {$urandom, $urandom};
               last_word       = {$urandom, $urandom};
               sender_idle_pct = 0;
               sink_stall_pct  = 76;
            end
            default: begin
               key_word        = '0;
               last_word       = '0;
               sender_idle_pct = 30;
               sink_stall_pct  = 30;
            end
         endcase
         write_reg(ppxc_pkg::CSR_KEY_LOW, key_word);
         write_reg(ppxc_pkg::CSR_KEY_LAST, last_word);
         // A write to an unused index must leave the key as it is.
         if (phase == 3) write_reg(CSR_IDX_SPARE, {$urandom, $urandom});
         csr_bus.valid <= 1'b0;

         phase_items = 0;
         while (phase_items < 400) begin
            // Halfway through the stalling phase the sender holds off once until the
            // receiver has taken everything that is outstanding.
            if (phase == 2 && !pressure_done && phase_items >= 200) begin
               drain_results();
               pressure_done = 1'b1;
            end
            send_packet();
         end
         drain_results();
      end

      repeat (4) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("tb_packet_payload_xor_cipher: done, clean");
      end else begin
         $display("tb_packet_payload_xor_cipher: done, errors");
      end
      $finish;
   end

   // The slowest correct run takes well under a tenth of this time.
   initial begin
      #10_000_000;
      $display("tb_packet_payload_xor_cipher: done, errors");
      $finish;
   end

endmodule
